/* rtl/msq_pkg.sv */
package msq_pkg;

   // Request and result payloads
   typedef struct packed {
      logic        command;
      logic [1:0]  phy_select;
      logic [15:0] ext_address;
      logic [15:0] write_value;
   } req_type;

   typedef struct packed {
      logic        frame_is_read;
      logic [4:0]  bus_phy_address;
      logic [4:0]  frame_register;
      logic [15:0] frame_data;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Configuration register indexes
   localparam logic CSR_PHY_A = 1'b0;
   localparam logic CSR_PHY_B = 1'b1;

   // PHY select codes
   localparam logic [1:0] SEL_PHY_A = 2'd1;
   localparam logic [1:0] SEL_PHY_B = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_PHY  = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

   // Clause 22 registers used for indirect access
   localparam logic [4:0] REG_REGCR = 5'd13;
   localparam logic [4:0] REG_ADDAR = 5'd14;

   // MMD device codes
   localparam logic [4:0] MMD_VENDOR = 5'h1F;
   localparam logic [4:0] MMD_PMA    = 5'h01;
   localparam logic [4:0] MMD_PCS    = 5'h03;

   // REGCR function field: data, no post increment
   localparam logic [15:0] REGCR_FUNC_DATA = 16'h4000;

   // Address ranges
   localparam logic [15:0] ADDR_DIRECT_END = 16'd32;
   localparam logic [15:0] ADDR_VENDOR_END = 16'h1000;
   localparam logic [15:0] ADDR_PMA_LAST   = 16'h1FFF;
   localparam logic [15:0] ADDR_PCS_FIRST  = 16'h3000;
   localparam logic [15:0] ADDR_PCS_END    = 16'h3002;
   localparam logic [15:0] ADDR_INNER_MASK = 16'h0FFF;

   // Frame slots of an indirect access
   localparam logic [1:0] FRAME_SET_MMD  = 2'd0;
   localparam logic [1:0] FRAME_SET_ADDR = 2'd1;
   localparam logic [1:0] FRAME_SET_DATA = 2'd2;
   localparam logic [1:0] FRAME_ACCESS   = 2'd3;

   // Classified access
   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_INDIRECT,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        is_read;
      logic [4:0]  bus;
      logic [4:0]  mmd;
      logic [15:0] inner;
      logic [15:0] data;
      logic [1:0]  status;
   } desc_type;

endpackage

/* rtl/mdio_mmd_indirect_access_sequencer.sv */
// Each request is written into the queue, and its frames are registered onto rsp.
// A direct or rejected access gives one frame, an MMD indirect access four frames,
// one frame per cycle from the frame sequencer in the back end.
// Up to QUEUE_DEPTH requests wait in the queue; busy is high while it is full.
// Synchronous active-high reset empties the queue, drops rsp_valid and sets the
// bus addresses to 0 (PHY A) and 1 (PHY B). The receiver cannot stall.
module mdio_mmd_indirect_access_sequencer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  msq_pkg::req_type req_item,
   output logic             rsp_valid,
   output msq_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [4:0]       csr_data
);
   import msq_pkg::*;

   logic     queue_full;
   logic     queue_empty;
   logic     push;
   logic     pop;
   desc_type push_desc;
   desc_type head_desc;

   // Request decode and configuration
   msq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   // Decoupling queue
   msq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (queue_empty)
   );

   // Frame sequencer
   msq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head_desc (head_desc),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* rtl/msq_front.sv */
module msq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msq_pkg::req_type  req_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [4:0]        csr_data,
   input  logic              queue_full,
   output logic              push,
   output msq_pkg::desc_type push_desc
);
   import msq_pkg::*;

   logic [4:0] phy_a_ff, phy_a_in;
   logic [4:0] phy_b_ff, phy_b_in;
   logic [4:0] bus;
   logic       addr_ok;
   logic       sel_ok;
   logic [4:0] mmd;
   logic [15:0] inner;
   logic       direct;

   assign csr_ready = 1'b1;
   assign busy      = queue_full;
   assign push      = start && !queue_full;

   // Bus address registers
   always_comb begin
      phy_a_in = phy_a_ff;
      phy_b_in = phy_b_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHY_A: phy_a_in = csr_data;
            CSR_PHY_B: phy_b_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phy_a_ff <= 5'd0;
         phy_b_ff <= 5'd1;
      end else begin
         phy_a_ff <= phy_a_in;
         phy_b_ff <= phy_b_in;
      end
   end

   // Address range decode
   always_comb begin
      addr_ok = 1'b1;
      direct  = 1'b0;
      mmd     = MMD_VENDOR;
      inner   = req_item.ext_address;
      if (req_item.ext_address < ADDR_DIRECT_END) begin
         direct = 1'b1;
      end else if (req_item.ext_address < ADDR_VENDOR_END) begin
         mmd = MMD_VENDOR;
      end else if (req_item.ext_address <= ADDR_PMA_LAST) begin
         mmd   = MMD_PMA;
         inner = req_item.ext_address & ADDR_INNER_MASK;
      end else if (req_item.ext_address >= ADDR_PCS_FIRST &&
                   req_item.ext_address < ADDR_PCS_END) begin
         mmd   = MMD_PCS;
         inner = req_item.ext_address & ADDR_INNER_MASK;
      end else begin
         addr_ok = 1'b0;
      end
   end

   // PHY select decode
   always_comb begin
      sel_ok = 1'b1;
      bus    = phy_a_ff;
      unique case (req_item.phy_select)
         SEL_PHY_A: bus = phy_a_ff;
         SEL_PHY_B: bus = phy_b_ff;
         default:   sel_ok = 1'b0;
      endcase
   end

   // Descriptor for the back end; address error wins over PHY error
   always_comb begin
      push_desc         = '0;
      push_desc.kind    = direct ? KIND_DIRECT : KIND_INDIRECT;
      push_desc.is_read = ~req_item.command;
      push_desc.bus     = bus;
      push_desc.mmd     = mmd;
      push_desc.inner   = inner;
      push_desc.data    = req_item.command ? req_item.write_value : 16'd0;
      push_desc.status  = STATUS_OK;
      if (!addr_ok) begin
         push_desc        = '0;
         push_desc.kind   = KIND_ERROR;
         push_desc.status = STATUS_BAD_ADDR;
      end else if (!sel_ok) begin
         push_desc        = '0;
         push_desc.kind   = KIND_ERROR;
         push_desc.status = STATUS_BAD_PHY;
      end
   end

endmodule

/* rtl/msq_queue.sv */
module msq_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msq_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output msq_pkg::desc_type head_desc,
   output logic              empty
);
   import msq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   desc_type         entries [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign head_desc = entries[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full request queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty request queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("request queue count overflow");
`endif

endmodule

/* rtl/msq_back.sv */
module msq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  msq_pkg::desc_type head_desc,
   output logic              pop,
   output logic              rsp_valid,
   output msq_pkg::rsp_type  rsp_item
);
   import msq_pkg::*;

   logic [1:0] frame_idx_ff, frame_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_item_ff, rsp_item_in;
   rsp_type    frame;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Build the frame for the current slot of the head request
   always_comb begin
      frame                 = '0;
      frame.bus_phy_address = head_desc.bus;
      frame.status          = STATUS_OK;
      unique case (head_desc.kind)
         KIND_DIRECT: begin
            frame.frame_is_read  = head_desc.is_read;
            frame.frame_register = head_desc.inner[4:0];
            frame.frame_data     = head_desc.data;
            frame.last           = 1'b1;
         end
         KIND_INDIRECT: begin
            case (frame_idx_ff)
               FRAME_SET_MMD: begin
                  frame.frame_register = REG_REGCR;
                  frame.frame_data     = {11'd0, head_desc.mmd};
               end
               FRAME_SET_ADDR: begin
                  frame.frame_register = REG_ADDAR;
                  frame.frame_data     = head_desc.inner;
               end
               FRAME_SET_DATA: begin
                  frame.frame_register = REG_REGCR;
                  frame.frame_data     = REGCR_FUNC_DATA | {11'd0, head_desc.mmd};
               end
               default: begin
                  frame.frame_is_read  = head_desc.is_read;
                  frame.frame_register = REG_ADDAR;
                  frame.frame_data     = head_desc.data;
                  frame.last           = 1'b1;
               end
            endcase
         end
         default: begin
            frame        = '0;
            frame.status = head_desc.status;
            frame.last   = 1'b1;
         end
      endcase
   end

   // One frame per cycle while the queue is not empty; pop with the final one
   always_comb begin
      pop          = !empty && frame.last;
      rsp_valid_in = !empty;
      rsp_item_in  = frame;
      frame_idx_in = frame_idx_ff;
      if (!empty) begin
         frame_idx_in = frame.last ? FRAME_SET_MMD : frame_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_idx_ff <= FRAME_SET_MMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_idx_ff <= frame_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

`ifndef SYNTHESIS
   a_frames_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.last |=> rsp_valid_ff)
      else $error("indirect access frames not contiguous");
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.status != STATUS_OK |-> rsp_item_ff.last)
      else $error("error result not marked last");
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.frame_is_read |-> rsp_item_ff.frame_data == '0)
      else $error("read frame carries data");
`endif

endmodule
